FILE: hw/rtl/iira_pkg.sv
// Package for the indexed insert/remove array.
// Holds command, status and cell operation codes and the cell control struct.
// No dependencies.
`default_nettype none

package iira_pkg;

  localparam int POS_W         = 13;
  localparam int CAP_W         = 9;
  localparam int POS_IN_W      = 9;
  localparam int VAL_W         = 32;
  localparam int FOUND_W       = 8;
  localparam int CMD_W         = 3;
  localparam int STATUS_W      = 3;
  localparam int FIND_GRP_BITS = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_INSERT     = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_POP_FRONT  = 3'd4,
    CMD_REMOVE     = 3'd5,
    CMD_READ       = 3'd6,
    CMD_FIND       = 3'd7
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_RANGE    = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_NEGFIX   = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,
    OP_INS  = 2'd1,
    OP_REM  = 2'd2,
    OP_FIND = 2'd3
  } cell_op_e;

  typedef struct packed {
    cell_op_e           op;
    logic [POS_W-1:0]   idx;
    logic [POS_W-1:0]   cnt;
  } cell_ctl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/indexed_insert_remove_array_core.sv
// Indexed insert/remove array: a row of DEPTH cells that shift as one per command.
// A result is registered from the execute state, or for find after the EXEC, FIND1 and FIND2 states.
// Items are taken only in the idle state, so a new item waits until the last one is through the
// one-step shift of the cell row or the two-level registered search; a held result stalls the next.
// Reset clears all cells and the length at once and sets the capacity to 256.
// Depends on iira_pkg, iira_cell and iira_find.
`default_nettype none

module indexed_insert_remove_array_core #(
  parameter int DEPTH      = 256,
  parameter int ELEM_WIDTH = 32
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [iira_pkg::CMD_W-1:0]   command_i,
  input  wire logic [iira_pkg::VAL_W-1:0]   element_value_i,
  input  wire logic signed [iira_pkg::POS_IN_W-1:0] position_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic      [iira_pkg::VAL_W-1:0]   result_value_o,
  output logic      [iira_pkg::FOUND_W-1:0] found_position_o,
  output logic      [iira_pkg::STATUS_W-1:0] status_o,
  output logic      [iira_pkg::CAP_W-1:0]   length_now_o,
  output logic                              is_empty_o,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [iira_pkg::CAP_W-1:0]   capacity_limit_i
);
  import iira_pkg::*;

  localparam int LW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);
  localparam int MW = (LW > 10) ? LW : 10;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_FIND1 = 2'd2;
  localparam logic [1:0] S_FIND2 = 2'd3;

  logic [1:0]            state_d, state_q;
  cmd_e                  cmd_q;
  logic [ELEM_WIDTH-1:0] val_q;
  logic [POS_IN_W-1:0]   pos_q;
  logic [LW-1:0]         count_d, count_q;
  logic [CAP_W-1:0]      cap_q;

  logic                  out_valid_d, out_valid_q;
  logic [VAL_W-1:0]      result_d, result_q;
  logic [FOUND_W-1:0]    found_d, found_q;
  status_e               status_d, status_q;

  logic [ELEM_WIDTH-1:0] cells [DEPTH];
  logic [DEPTH-1:0]      hits;
  cell_ctl_t             ctl;
  logic                  find_any;
  logic [IW-1:0]         find_idx;

  logic [MW-1:0]         cnt_m, cap_m, effcap, pos_sx, idx_m;
  logic                  neg, is_ins, is_rem, ins_ok, rem_ok, adv, produce;
  logic [ELEM_WIDTH-1:0] rd_data, res_x;
  status_e               st_x;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ELEM_WIDTH-1:0] lower, upper;
    if (i == 0) begin : g_lo0
      assign lower = '0;
    end else begin : g_lo
      assign lower = cells[i-1];
    end
    if (i == DEPTH - 1) begin : g_hitop
      assign upper = '0;
    end else begin : g_hi
      assign upper = cells[i+1];
    end
    iira_cell #(
      .W   (ELEM_WIDTH),
      .IDX (i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .new_i   (val_q),
      .lower_i (lower),
      .upper_i (upper),
      .data_o  (cells[i]),
      .hit_o   (hits[i])
    );
  end

  iira_find #(
    .DEPTH (DEPTH),
    .IW    (IW)
  ) u_find (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .hit_i  (hits),
    .any_o  (find_any),
    .idx_o  (find_idx)
  );

  assign cnt_m  = MW'(count_q);
  assign cap_m  = MW'(cap_q);
  assign effcap = (cap_m > MW'(DEPTH)) ? MW'(DEPTH) : cap_m;
  assign pos_sx = {{(MW - POS_IN_W){pos_q[POS_IN_W-1]}}, pos_q};
  assign adv    = !out_valid_q || out_ready_i;

  always_comb begin
    idx_m  = '0;
    neg    = 1'b0;
    is_ins = 1'b0;
    is_rem = 1'b0;
    unique case (cmd_q)
      CMD_PUSH_BACK: begin
        idx_m  = cnt_m;
        is_ins = 1'b1;
      end
      CMD_PUSH_FRONT: begin
        is_ins = 1'b1;
      end
      CMD_INSERT: begin
        idx_m  = pos_sx;
        neg    = pos_q[POS_IN_W-1];
        is_ins = 1'b1;
      end
      CMD_POP_BACK: begin
        idx_m  = cnt_m - MW'(1);
        is_rem = 1'b1;
      end
      CMD_POP_FRONT: begin
        is_rem = 1'b1;
      end
      CMD_REMOVE: begin
        idx_m  = pos_sx;
        neg    = pos_q[POS_IN_W-1];
        is_rem = 1'b1;
      end
      CMD_READ: begin
        neg   = pos_q[POS_IN_W-1];
        idx_m = neg ? (~pos_sx + MW'(1)) : pos_sx;
      end
      CMD_FIND: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    rd_data = '0;
    if (idx_m < MW'(DEPTH)) begin
      rd_data = cells[IW'(idx_m)];
    end
  end

  always_comb begin
    st_x   = ST_OK;
    res_x  = '0;
    ins_ok = 1'b0;
    rem_ok = 1'b0;
    if (is_ins) begin
      if (neg || (idx_m > cnt_m)) begin
        st_x = ST_RANGE;
      end else if (cnt_m >= effcap) begin
        st_x = ST_FULL;
      end else begin
        ins_ok = 1'b1;
      end
    end else if (is_rem) begin
      if (count_q == '0) begin
        st_x = ST_EMPTY;
      end else if (neg || (idx_m >= cnt_m)) begin
        st_x = ST_RANGE;
      end else begin
        rem_ok = 1'b1;
        res_x  = rd_data;
      end
    end else if (cmd_q == CMD_READ) begin
      st_x = neg ? ST_NEGFIX : ST_OK;
      if (idx_m >= effcap) begin
        st_x = ST_RANGE;
      end else begin
        res_x = rd_data;
      end
    end
  end

  always_comb begin
    ctl.idx = POS_W'(idx_m);
    ctl.cnt = POS_W'(count_q);
    ctl.op  = OP_HOLD;
    if (state_q == S_EXEC) begin
      if (cmd_q == CMD_FIND) begin
        ctl.op = OP_FIND;
      end else if (adv && ins_ok) begin
        ctl.op = OP_INS;
      end else if (adv && rem_ok) begin
        ctl.op = OP_REM;
      end
    end
  end

  assign produce = ((state_q == S_EXEC) && (cmd_q != CMD_FIND)) || (state_q == S_FIND2);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    out_valid_d = out_valid_q;
    result_d    = result_q;
    found_d     = found_q;
    status_d    = status_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cmd_q == CMD_FIND) begin
          state_d = S_FIND1;
        end else if (adv) begin
          state_d = S_IDLE;
        end
      end
      S_FIND1: begin
        state_d = S_FIND2;
      end
      S_FIND2: begin
        if (adv) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (produce && adv) begin
      out_valid_d = 1'b1;
      if (state_q == S_FIND2) begin
        result_d = '0;
        found_d  = find_any ? FOUND_W'(find_idx) : '0;
        status_d = find_any ? ST_OK : ST_NOTFOUND;
      end else begin
        result_d = VAL_W'(res_x);
        found_d  = '0;
        status_d = st_x;
        if (ins_ok) begin
          count_d = count_q + LW'(1);
        end else if (rem_ok) begin
          count_d = count_q - LW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      cap_q       <= CAP_W'(256);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        cap_q <= capacity_limit_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q <= cmd_e'(command_i);
      val_q <= ELEM_WIDTH'(element_value_i);
      pos_q <= position_i;
    end
    result_q <= result_d;
    found_q  <= found_d;
    status_q <= status_d;
  end

  assign in_ready_o       = (state_q == S_IDLE);
  assign cfg_ready_o      = 1'b1;
  assign out_valid_o      = out_valid_q;
  assign result_value_o   = result_q;
  assign found_position_o = found_q;
  assign status_o         = status_q;
  assign length_now_o     = CAP_W'(count_q);
  assign is_empty_o       = (count_q == '0);

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= LW'(DEPTH))
    else $error("Length exceeds the number of cells.");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_EXEC))
    else $error("Accepted item did not enter execution.");

  a_count_only_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_EXEC) |=> $stable(count_q))
    else $error("Length changed outside execution.");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC) |=> ((count_q == $past(count_q)) ||
                             (count_q == $past(count_q) + LW'(1)) ||
                             (count_q == $past(count_q) - LW'(1))))
    else $error("Length changed by more than one.");

  a_result_needs_cells: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl.op == OP_INS || ctl.op == OP_REM) |-> (produce && adv))
    else $error("Cell row shifted without delivering a result.");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/iira_cell.sv
// One storage cell of the array row: holds one element and its find hit flag.
// Shifts from either neighbor or loads the new element under the broadcast control.
// Depends on iira_pkg.
`default_nettype none

module iira_cell #(
  parameter int W   = 32,
  parameter int IDX = 0
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire iira_pkg::cell_ctl_t ctl_i,
  input  wire logic [W-1:0]       new_i,
  input  wire logic [W-1:0]       lower_i,
  input  wire logic [W-1:0]       upper_i,
  output logic      [W-1:0]       data_o,
  output logic                    hit_o
);
  import iira_pkg::*;

  logic [POS_W-1:0] me;
  logic [W-1:0]     data_d, data_q;
  logic             hit_d, hit_q;

  assign me = POS_W'(IDX);

  always_comb begin
    data_d = data_q;
    hit_d  = hit_q;
    unique case (ctl_i.op)
      OP_INS: begin
        if (me == ctl_i.idx) begin
          data_d = new_i;
        end else if ((me > ctl_i.idx) && (me <= ctl_i.cnt)) begin
          data_d = lower_i;
        end
      end
      OP_REM: begin
        if ((me >= ctl_i.idx) && (({1'b0, me} + 1'b1) < {1'b0, ctl_i.cnt})) begin
          data_d = upper_i;
        end
      end
      OP_FIND: begin
        hit_d = (data_q == new_i) && (me < ctl_i.cnt);
      end
      OP_HOLD: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
      hit_q  <= 1'b0;
    end else begin
      data_q <= data_d;
      hit_q  <= hit_d;
    end
  end

  assign data_o = data_q;
  assign hit_o  = hit_q;

endmodule

`default_nettype wire

FILE: hw/rtl/iira_find.sv
// Two-level registered search for the first set hit flag of the cell row.
// Groups of cells are encoded into registers, then the first group is picked.
// Depends on iira_pkg.
`default_nettype none

module iira_find #(
  parameter int DEPTH = 256,
  parameter int IW    = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [DEPTH-1:0] hit_i,
  output logic                  any_o,
  output logic      [IW-1:0]    idx_o
);
  import iira_pkg::*;

  localparam int G  = 1 << FIND_GRP_BITS;
  localparam int NG = (DEPTH + G - 1) / G;
  localparam int GB = (NG > 1) ? $clog2(NG) : 1;

  logic [NG*G-1:0]          hit_pad;
  logic [NG-1:0]            grp_any_d, grp_any_q;
  logic [FIND_GRP_BITS-1:0] grp_loc_d [NG];
  logic [FIND_GRP_BITS-1:0] grp_loc_q [NG];
  logic [GB-1:0]            gsel;

  assign hit_pad = (NG*G)'(hit_i);

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_any_d[g] = |hit_pad[g*G +: G];
      grp_loc_d[g] = '0;
      for (int j = G - 1; j >= 0; j--) begin
        if (hit_pad[g*G + j]) begin
          grp_loc_d[g] = FIND_GRP_BITS'(j);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_any_q <= '0;
      for (int g = 0; g < NG; g++) begin
        grp_loc_q[g] <= '0;
      end
    end else begin
      grp_any_q <= grp_any_d;
      for (int g = 0; g < NG; g++) begin
        grp_loc_q[g] <= grp_loc_d[g];
      end
    end
  end

  always_comb begin
    gsel = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (grp_any_q[g]) begin
        gsel = GB'(g);
      end
    end
  end

  assign any_o = |grp_any_q;
  assign idx_o = IW'({gsel, grp_loc_q[gsel]});

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
// Self-checking testbench for indexed_insert_remove_array_core: directed corner items,
// then random command mixes under several capacity settings, checked by a scoreboard.
// Depends on iira_pkg and the core; needs no files or arguments.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import iira_pkg::*;

  localparam int ARRAY_DEPTH = 256;
  localparam int QUIET_LIMIT = 5000;

  typedef struct {
    logic [VAL_W-1:0]    value;
    logic [FOUND_W-1:0]  found;
    logic [STATUS_W-1:0] status;
    logic [CAP_W-1:0]    length;
    logic                empty;
  } array_result_t;

  class array_scoreboard;
    logic [VAL_W-1:0] cells [ARRAY_DEPTH];
    int count;
    int capacity;
    array_result_t expected_results [$];
    int unsigned mismatches;
    int unsigned results_seen;

    function new();
      foreach (cells[i]) cells[i] = '0;
      count = 0;
      capacity = 256;
      mismatches = 0;
      results_seen = 0;
    endfunction

    function int usable_capacity();
      return (capacity > ARRAY_DEPTH) ? ARRAY_DEPTH : capacity;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] value);
      capacity = int'(value);
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function status_e insert_at(int idx, logic [VAL_W-1:0] value);
      if (idx < 0 || idx > count) return ST_RANGE;
      if (count >= usable_capacity()) return ST_FULL;
      for (int i = count; i > idx; i--) cells[i] = cells[i-1];
      cells[idx] = value;
      count++;
      return ST_OK;
    endfunction

    function status_e take_at(int idx, output logic [VAL_W-1:0] value);
      value = '0;
      if (count == 0) return ST_EMPTY;
      if (idx < 0 || idx >= count) return ST_RANGE;
      value = cells[idx];
      for (int i = idx; i + 1 < count; i++) cells[i] = cells[i+1];
      count--;
      return ST_OK;
    endfunction

    function void note_command(cmd_e cmd, logic [VAL_W-1:0] value,
                               logic signed [POS_IN_W-1:0] pos);
      array_result_t r;
      int p;
      r.value = '0;
      r.found = '0;
      r.status = ST_OK;
      p = pos;
      case (cmd)
        CMD_PUSH_BACK:  r.status = insert_at(count, value);
        CMD_PUSH_FRONT: r.status = insert_at(0, value);
        CMD_INSERT:     r.status = insert_at(p, value);
        CMD_POP_BACK:   r.status = take_at(count - 1, r.value);
        CMD_POP_FRONT:  r.status = take_at(0, r.value);
        CMD_REMOVE:     r.status = take_at(p, r.value);
        CMD_READ: begin
          if (p < 0) begin
            p = -p;
            r.status = ST_NEGFIX;
          end
          if (p >= usable_capacity()) r.status = ST_RANGE;
          else r.value = cells[p];
        end
        default: begin
          r.status = ST_NOTFOUND;
          for (int i = 0; i < count; i++) begin
            if (cells[i] == value) begin
              r.found = i[FOUND_W-1:0];
              r.status = ST_OK;
              break;
            end
          end
        end
      endcase
      r.length = count[CAP_W-1:0];
      r.empty = (count == 0);
      expected_results.push_back(r);
    endfunction

    function void check_result(array_result_t got);
      array_result_t want;
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result %0d: value %h found %0d status %0d length %0d empty %b",
                   results_seen, got.value, got.found, got.status, got.length, got.empty);
        return;
      end
      want = expected_results.pop_front();
      if (got.value !== want.value || got.found !== want.found ||
          got.status !== want.status || got.length !== want.length ||
          got.empty !== want.empty) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Mismatch on result %0d:", results_seen);
          $display("  expected value %h found %0d status %0d length %0d empty %b",
                   want.value, want.found, want.status, want.length, want.empty);
          $display("  actual   value %h found %0d status %0d length %0d empty %b",
                   got.value, got.found, got.status, got.length, got.empty);
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic [CMD_W-1:0] command = '0;
  logic [VAL_W-1:0] element_value = '0;
  logic signed [POS_IN_W-1:0] position = '0;
  logic out_ready = 1'b0;
  logic cfg_valid = 1'b0;
  logic [CAP_W-1:0] cfg_capacity = '0;

  logic in_ready_o;
  logic out_valid_o;
  logic [VAL_W-1:0] result_value_o;
  logic [FOUND_W-1:0] found_position_o;
  logic [STATUS_W-1:0] status_o;
  logic [CAP_W-1:0] length_now_o;
  logic is_empty_o;
  logic cfg_ready_o;

  array_scoreboard sb = new();
  int unsigned items_sent = 0;
  int quiet_cycles = 0;
  logic hold_request = 1'b0;

  always #2 clk_i = ~clk_i;

  indexed_insert_remove_array_core #(
    .DEPTH      (ARRAY_DEPTH),
    .ELEM_WIDTH (VAL_W)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready_o),
    .command_i        (command),
    .element_value_i  (element_value),
    .position_i       (position),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready),
    .result_value_o   (result_value_o),
    .found_position_o (found_position_o),
    .status_o         (status_o),
    .length_now_o     (length_now_o),
    .is_empty_o       (is_empty_o),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready_o),
    .capacity_limit_i (cfg_capacity)
  );

  always @(posedge clk_i) begin
    array_result_t got;
    if (rst_ni) begin
      if (out_valid_o && out_ready) begin
        got.value = result_value_o;
        got.found = found_position_o;
        got.status = status_o;
        got.length = length_now_o;
        got.empty = is_empty_o;
        sb.check_result(got);
      end
      if (in_valid && in_ready_o) sb.note_command(cmd_e'(command), element_value, position);
      if (cfg_valid && cfg_ready_o) sb.set_capacity(cfg_capacity);
      if ((out_valid_o && out_ready) || (in_valid && in_ready_o) || (cfg_valid && cfg_ready_o))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
  end

  initial begin
    @(posedge rst_ni);
    while (quiet_cycles < QUIET_LIMIT) @(negedge clk_i);
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic int sender_idle_pct();
    if (items_sent < 650) return 32;
    if (items_sent < 1300) return 49;
    return 0;
  endfunction

  function automatic int receiver_idle_pct();
    if (items_sent < 650) return 49;
    if (items_sent < 1300) return 32;
    return 0;
  endfunction

  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (80) @(negedge clk_i);
      end else begin
        out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct());
      end
    end
  end

  task automatic send_item(cmd_e cmd, logic [VAL_W-1:0] value,
                           logic signed [POS_IN_W-1:0] pos);
    while ($urandom_range(0, 99) < sender_idle_pct()) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    command <= cmd;
    element_value <= value;
    position <= pos;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_capacity <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [VAL_W-1:0] pick_value(cmd_e cmd);
    int r;
    r = $urandom_range(0, 99);
    if (cmd == CMD_FIND && sb.count > 0 && r < 60)
      return sb.cells[$urandom_range(0, sb.count - 1)];
    if (r < 25) return VAL_W'($urandom_range(0, 7));
    if (r < 30) return {VAL_W{1'b1}};
    return $urandom;
  endfunction

  function automatic logic signed [POS_IN_W-1:0] pick_position(cmd_e cmd);
    int r;
    int top;
    r = $urandom_range(0, 99);
    if (r < 10) return POS_IN_W'($urandom_range(0, 511));
    if (r < 15) begin
      top = $urandom_range(1, 3);
      return POS_IN_W'(-top);
    end
    if (r < 22) return POS_IN_W'(sb.count + $urandom_range(0, 1));
    case (cmd)
      CMD_INSERT: top = sb.count;
      CMD_REMOVE: top = (sb.count > 0) ? sb.count - 1 : 0;
      default:    top = (r < 60) ? sb.count : sb.usable_capacity();
    endcase
    return POS_IN_W'($urandom_range(0, top));
  endfunction

  task automatic run_random(int items, int grow_pct);
    cmd_e cmd;
    int r;
    repeat (items) begin
      r = $urandom_range(0, 99);
      if (r < 12) cmd = CMD_READ;
      else if (r < 25) cmd = CMD_FIND;
      else if ($urandom_range(0, 99) < grow_pct) cmd = cmd_e'($urandom_range(0, 2));
      else cmd = cmd_e'($urandom_range(3, 5));
      send_item(cmd, pick_value(cmd), pick_position(cmd));
    end
  endtask

  initial begin
    int phase_items [8];
    int phase_grow [8];
    logic [CAP_W-1:0] phase_cap [8];
    phase_items = '{450, 300, 100, 40, 200, 200, 300, 330};
    phase_grow = '{92, 15, 50, 50, 60, 55, 55, 50};
    phase_cap = '{9'd256, 9'd256, 9'd1, 9'd0, 9'd511, 9'd8, 9'd0, 9'd256};
    phase_cap[6] = CAP_W'($urandom_range(2, 255));
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Corner cases on the empty array, then a small array of four distinct values.
    send_item(CMD_POP_BACK, 32'h0, 9'h000);
    send_item(CMD_POP_FRONT, 32'h0, 9'h000);
    send_item(CMD_REMOVE, 32'h0, 9'h000);
    send_item(CMD_FIND, 32'h0, 9'h000);
    send_item(CMD_READ, 32'h0, 9'h000);
    send_item(CMD_READ, 32'h0, 9'h1FF);
    send_item(CMD_READ, 32'h0, 9'h100);
    send_item(CMD_READ, 32'h0, 9'h0FF);
    send_item(CMD_INSERT, 32'h1, 9'h1FF);
    send_item(CMD_INSERT, 32'h1, 9'h001);
    send_item(CMD_PUSH_BACK, 32'hFFFF_FFFF, 9'h000);
    send_item(CMD_PUSH_FRONT, 32'h0, 9'h000);
    send_item(CMD_INSERT, 32'hA5A5_A5A5, 9'h001);
    send_item(CMD_INSERT, 32'h5, 9'h003);
    send_item(CMD_FIND, 32'h0, 9'h000);
    send_item(CMD_FIND, 32'hFFFF_FFFF, 9'h000);
    send_item(CMD_REMOVE, 32'h0, 9'h004);
    send_item(CMD_REMOVE, 32'h0, 9'h1FF);
    send_item(CMD_POP_BACK, 32'h0, 9'h000);
    send_item(CMD_READ, 32'h0, 9'h003);
    send_item(CMD_POP_FRONT, 32'h0, 9'h000);
    send_item(CMD_REMOVE, 32'h0, 9'h001);
    drain_results();
    write_capacity(9'd2);
    send_item(CMD_PUSH_BACK, 32'h7, 9'h000);
    send_item(CMD_PUSH_FRONT, 32'h8, 9'h000);
    send_item(CMD_INSERT, 32'h9, 9'h005);
    send_item(CMD_READ, 32'h0, 9'h002);
    send_item(CMD_READ, 32'h0, 9'h1FF);
    drain_results();

    for (int ph = 0; ph < 8; ph++) begin
      write_capacity(phase_cap[ph]);
      if (ph == 0 || ph == 4) hold_request = 1'b1;
      run_random(phase_items[ph], phase_grow[ph]);
      drain_results();
    end

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
